### src/ifla_pkg.sv
// Package of the index free-list allocator: field widths, null link, command,
// status, controller state and datapath operation codes, and the status and
// control bundles between controller and datapath. Depends on nothing.
`default_nettype none

package ifla_pkg;

    localparam int MAX_INDICES_DEF = 64;

    localparam int CMD_W  = 3;
    localparam int IDX_W  = 6;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;
    localparam int LINK_W = 7;

    // Link value that marks the end of a list.
    localparam logic [LINK_W-1:0] NIL_LINK = 7'd127;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC       = 3'd0,
        CMD_RELEASE     = 3'd1,
        CMD_REL_OLDEST  = 3'd2,
        CMD_REL_ALL     = 3'd3,
        CMD_LIST        = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 2'd0,
        ST_EXHAUSTED   = 2'd1,
        ST_INVALID     = 2'd2,
        ST_NONE_IN_USE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ALLOC1,
        S_ALLOC2,
        S_ALLOC3,
        S_SRCH,
        S_SRCH_ADV,
        S_OLD_RD,
        S_OLD_CHK,
        S_REL2,
        S_REL3,
        S_REL4,
        S_REL5,
        S_LIST_RD,
        S_LIST_CHK,
        S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_SET_RES,
        OP_REINIT,
        OP_ALLOC_START,
        OP_ALLOC_W1,
        OP_ALLOC_W2,
        OP_ALLOC_W3,
        OP_WALK_START,
        OP_RD_NODE,
        OP_ADV,
        OP_REL2,
        OP_REL3,
        OP_REL4,
        OP_REL5,
        OP_LIST_RES,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status res_status;
    } t_dp_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic pool_full;
        logic used_zero;
        logic head_valid;
        logic node_valid;
        logic node_eq_want;
        logic step_limit;
        logic rd_next_valid;
        logic out_free;
        logic res_last;
    } t_dp_stat;

endpackage

`default_nettype wire

### src/ifla_ifs.sv
// Channel interfaces of the index free-list allocator: command, result and
// configuration write. Each carries valid, ready and its payload.
// Depends on ifla_pkg for the field widths.
`default_nettype none

interface ifla_cmd_if import ifla_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  index;

    modport source (output valid, output command, output index, input ready);
    modport sink   (input valid, input command, input index, output ready);
endinterface

interface ifla_res_if import ifla_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  index_res;
    logic [CNT_W-1:0]  used_count;
    logic              last;

    modport source (output valid, output status, output index_res, output used_count,
                    output last, input ready);
    modport sink   (input valid, input status, input index_res, input used_count,
                    input last, output ready);
endinterface

interface ifla_cfg_if import ifla_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CNT_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/index_free_list_allocator.sv
// Top level of the index free-list allocator: controller and datapath joined
// by command and status bundles. Depends on ifla_pkg, ifla_ifs, ifla_ctrl and ifla_dpath.
`default_nettype none

// The block hands out indices 0 to count-1 from a pool and takes them back,
// keeping a free list and a used list as doubly linked lists in two link
// memories (next and prev) of MAX_INDICES entries, each with a registered read
// port and one write port. One command beat is taken at a time; the command
// channel is ready again once the last result beat of the command has been
// loaded into the output register, so a new command can be taken while that
// beat still waits at the output. Every command gives one result beat except
// list, which gives one beat per used index, newest first, with last set on
// the final one. The command channel is ready again in the cycle after the
// final beat is loaded. The single read port of the link memories and its
// registered read put each hop along a list into its own cycle. After reset,
// release all or a count write, the link memories are not swept: per-entry
// valid bits, cleared at once, make unwritten entries read as the rebuilt
// list order, so the block takes commands in the first cycle after reset.
// Count writes are always taken and must only arrive while the block is
// idle; a count of zero acts as one and a count above MAX_INDICES as
// MAX_INDICES. A misused command returns an error status and changes nothing.
module index_free_list_allocator import ifla_pkg::*; #(
    parameter int MAX_INDICES = MAX_INDICES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ifla_cmd_if.sink    i_cmd,
    ifla_res_if.source  o_res,
    ifla_cfg_if.sink    i_cfg
);

    t_dp_ctrl dp_ctrl;
    t_dp_stat dp_stat;
    logic     in_ready;

    ifla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_stat     (dp_stat),
        .o_in_ready (in_ready),
        .o_ctrl     (dp_ctrl)
    );

    ifla_dpath #(.MAX_INDICES(MAX_INDICES)) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (dp_ctrl),
        .o_stat       (dp_stat),
        .i_command    (i_cmd.command),
        .i_index      (i_cmd.index),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_status     (o_res.status),
        .o_index_res  (o_res.index_res),
        .o_used_count (o_res.used_count),
        .o_last       (o_res.last)
    );

    assign i_cmd.ready = in_ready;

    // The count register accepts a write beat in every cycle.
    assign i_cfg.ready = 1'b1;

endmodule

`default_nettype wire

### src/ifla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on ifla_pkg for its default sizes.
`default_nettype none

module ifla_ram import ifla_pkg::*; #(
    parameter int WIDTH = LINK_W,
    parameter int DEPTH = MAX_INDICES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/ifla_ctrl.sv
// Controller of the index free-list allocator: the sequencer that walks each
// command through its datapath operations. Depends on ifla_pkg.
`default_nettype none

module ifla_ctrl import ifla_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_dp_stat i_stat,
    output      logic     o_in_ready,
    output      t_dp_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                unique case (i_stat.cmd)
                    CMD_ALLOC:      n_state = i_stat.pool_full ? S_EMIT : S_ALLOC1;
                    CMD_RELEASE:    n_state = i_stat.used_zero ? S_EMIT : S_SRCH;
                    CMD_REL_OLDEST: n_state = (i_stat.used_zero || !i_stat.head_valid)
                                              ? S_EMIT : S_OLD_RD;
                    CMD_LIST:       n_state = (i_stat.used_zero || !i_stat.head_valid)
                                              ? S_EMIT : S_LIST_RD;
                    default:        n_state = S_EMIT;
                endcase
            end
            S_ALLOC1:   n_state = S_ALLOC2;
            S_ALLOC2:   n_state = S_ALLOC3;
            S_ALLOC3:   n_state = S_EMIT;
            S_SRCH: begin
                priority if (i_stat.step_limit || !i_stat.node_valid) begin
                    n_state = S_EMIT;
                end else if (i_stat.node_eq_want) begin
                    n_state = S_REL2;
                end else begin
                    n_state = S_SRCH_ADV;
                end
            end
            S_SRCH_ADV: n_state = S_SRCH;
            S_OLD_RD:   n_state = i_stat.step_limit ? S_REL2 : S_OLD_CHK;
            S_OLD_CHK:  n_state = i_stat.rd_next_valid ? S_OLD_RD : S_REL2;
            S_REL2:     n_state = S_REL3;
            S_REL3:     n_state = S_REL4;
            S_REL4:     n_state = S_REL5;
            S_REL5:     n_state = S_EMIT;
            S_LIST_RD:  n_state = S_LIST_CHK;
            S_LIST_CHK: n_state = S_EMIT;
            S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.res_last ? S_IDLE : S_LIST_RD;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready            = 1'b0;
        o_ctrl.op             = OP_NONE;
        o_ctrl.res_status     = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctrl.op  = OP_LATCH;
            end
            S_CHECK: begin
                unique case (i_stat.cmd)
                    CMD_ALLOC: begin
                        if (i_stat.pool_full) begin
                            o_ctrl.op         = OP_SET_RES;
                            o_ctrl.res_status = ST_EXHAUSTED;
                        end else begin
                            o_ctrl.op = OP_ALLOC_START;
                        end
                    end
                    CMD_RELEASE: begin
                        if (i_stat.used_zero) begin
                            o_ctrl.op         = OP_SET_RES;
                            o_ctrl.res_status = ST_NONE_IN_USE;
                        end else begin
                            o_ctrl.op = OP_WALK_START;
                        end
                    end
                    CMD_REL_OLDEST, CMD_LIST: begin
                        if (i_stat.used_zero || !i_stat.head_valid) begin
                            o_ctrl.op         = OP_SET_RES;
                            o_ctrl.res_status = ST_NONE_IN_USE;
                        end else begin
                            o_ctrl.op = OP_WALK_START;
                        end
                    end
                    CMD_REL_ALL: o_ctrl.op = OP_REINIT;
                    default: begin
                        o_ctrl.op         = OP_SET_RES;
                        o_ctrl.res_status = ST_OK;
                    end
                endcase
            end
            S_ALLOC1:   o_ctrl.op = OP_ALLOC_W1;
            S_ALLOC2:   o_ctrl.op = OP_ALLOC_W2;
            S_ALLOC3:   o_ctrl.op = OP_ALLOC_W3;
            S_SRCH: begin
                priority if (i_stat.step_limit || !i_stat.node_valid) begin
                    o_ctrl.op         = OP_SET_RES;
                    o_ctrl.res_status = ST_INVALID;
                end else begin
                    o_ctrl.op = OP_RD_NODE;
                end
            end
            S_SRCH_ADV: o_ctrl.op = OP_ADV;
            S_OLD_RD:   o_ctrl.op = OP_RD_NODE;
            S_OLD_CHK:  o_ctrl.op = i_stat.rd_next_valid ? OP_ADV : OP_RD_NODE;
            S_REL2:     o_ctrl.op = OP_REL2;
            S_REL3:     o_ctrl.op = OP_REL3;
            S_REL4:     o_ctrl.op = OP_REL4;
            S_REL5:     o_ctrl.op = OP_REL5;
            S_LIST_RD:  o_ctrl.op = OP_RD_NODE;
            S_LIST_CHK: o_ctrl.op = OP_LIST_RES;
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_ctrl.op = OP_EMIT;
                end
            end
            default:    o_ctrl.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

### src/ifla_dpath.sv
// Datapath of the index free-list allocator: pool registers, the next and
// prev link memories with their valid bits, walk registers and the result
// register. Depends on ifla_pkg and ifla_ram.
`default_nettype none

module ifla_dpath import ifla_pkg::*; #(
    parameter int MAX_INDICES = MAX_INDICES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_ctrl          i_ctrl,
    output      t_dp_stat          o_stat,
    input  wire logic [CMD_W-1:0]  i_command,
    input  wire logic [IDX_W-1:0]  i_index,
    input  wire logic              i_cfg_we,
    input  wire logic [CNT_W-1:0]  i_cfg_data,
    input  wire logic              i_out_ready,
    output      logic              o_out_valid,
    output      logic [STAT_W-1:0] o_status,
    output      logic [IDX_W-1:0]  o_index_res,
    output      logic [CNT_W-1:0]  o_used_count,
    output      logic              o_last
);

    localparam int AW = $clog2(MAX_INDICES);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_INDICES);

    function automatic logic link_ok(input logic [LINK_W-1:0] l, input logic [CNT_W-1:0] c);
        return l < c;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [LINK_W-1:0] l);
        return l[AW-1:0];
    endfunction

    // Link values that an entry holds straight after the lists are rebuilt.
    function automatic logic [LINK_W-1:0] next_rst(input logic [AW-1:0] a,
                                                  input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] s;
        s = CNT_W'(a) + CNT_W'(1);
        return (s < c) ? LINK_W'(s) : NIL_LINK;
    endfunction

    function automatic logic [LINK_W-1:0] prev_rst(input logic [AW-1:0] a,
                                                  input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] w;
        w = CNT_W'(a);
        if (w >= c || w == '0) begin
            return NIL_LINK;
        end
        return LINK_W'(w - CNT_W'(1));
    endfunction

    logic [CNT_W-1:0]       r_count;
    logic [LINK_W-1:0]      r_free_head;
    logic [LINK_W-1:0]      r_used_head;
    logic [CNT_W-1:0]       r_used_total;
    logic [MAX_INDICES-1:0] r_nvalid;
    logic [MAX_INDICES-1:0] r_pvalid;
    logic                   r_out_valid;

    logic [CMD_W-1:0]       r_cmd;
    logic [IDX_W-1:0]       r_want;
    logic [LINK_W-1:0]      r_node;
    logic [LINK_W-1:0]      r_nx;
    logic [LINK_W-1:0]      r_pv;
    logic [CNT_W-1:0]       r_steps;
    logic [AW-1:0]          r_rd_addr;
    logic                   r_rd_nv;
    logic                   r_rd_pv;
    t_status                r_res_status;
    logic [IDX_W-1:0]       r_res_idx;
    logic                   r_res_last;
    logic [STAT_W-1:0]      r_out_status;
    logic [IDX_W-1:0]       r_out_idx;
    logic [CNT_W-1:0]       r_out_cnt;
    logic                   r_out_last;

    logic [AW-1:0]          raddr;
    logic                   nram_we;
    logic [AW-1:0]          nram_waddr;
    logic [LINK_W-1:0]      nram_wdata;
    logic [LINK_W-1:0]      nram_q;
    logic                   pram_we;
    logic [AW-1:0]          pram_waddr;
    logic [LINK_W-1:0]      pram_wdata;
    logic [LINK_W-1:0]      pram_q;
    logic [LINK_W-1:0]      rd_next;
    logic [LINK_W-1:0]      rd_prev;
    logic                   raddr_in_pool;
    logic                   list_end;
    logic [CNT_W-1:0]       cfg_cnt;

    ifla_ram #(.WIDTH(LINK_W), .DEPTH(MAX_INDICES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nram_we),
        .i_waddr (nram_waddr),
        .i_wdata (nram_wdata),
        .i_raddr (raddr),
        .o_rdata (nram_q)
    );

    ifla_ram #(.WIDTH(LINK_W), .DEPTH(MAX_INDICES)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pram_we),
        .i_waddr (pram_waddr),
        .i_wdata (pram_wdata),
        .i_raddr (raddr),
        .o_rdata (pram_q)
    );

    // An entry not written since the lists were rebuilt reads as its rebuilt value.
    assign rd_next = r_rd_nv ? nram_q : next_rst(r_rd_addr, r_count);
    assign rd_prev = r_rd_pv ? pram_q : prev_rst(r_rd_addr, r_count);

    assign raddr         = (i_ctrl.op == OP_ALLOC_START) ? addr_of(r_free_head)
                                                         : addr_of(r_node);
    assign raddr_in_pool = CNT_W'(raddr) < MAX_CNT;
    assign list_end      = !link_ok(rd_next, r_count) || (r_steps + CNT_W'(1) >= MAX_CNT);

    assign cfg_cnt = (i_cfg_data == '0)     ? CNT_W'(1) :
                     (i_cfg_data > MAX_CNT) ? MAX_CNT   : i_cfg_data;

    always_comb begin
        nram_we    = 1'b0;
        nram_waddr = addr_of(r_node);
        nram_wdata = NIL_LINK;
        pram_we    = 1'b0;
        pram_waddr = addr_of(r_node);
        pram_wdata = NIL_LINK;
        unique case (i_ctrl.op)
            OP_ALLOC_W1: begin
                pram_we    = link_ok(rd_next, r_count);
                pram_waddr = addr_of(rd_next);
                nram_we    = 1'b1;
                nram_wdata = r_used_head;
            end
            OP_ALLOC_W2: begin
                pram_we = 1'b1;
            end
            OP_ALLOC_W3: begin
                pram_we    = link_ok(r_used_head, r_count);
                pram_waddr = addr_of(r_used_head);
                pram_wdata = r_node;
            end
            OP_REL2: begin
                nram_we    = link_ok(rd_prev, r_count);
                nram_waddr = addr_of(rd_prev);
                nram_wdata = rd_next;
            end
            OP_REL3: begin
                pram_we    = link_ok(r_nx, r_count);
                pram_waddr = addr_of(r_nx);
                pram_wdata = r_pv;
                nram_we    = 1'b1;
                nram_wdata = r_free_head;
            end
            OP_REL4: begin
                pram_we = 1'b1;
            end
            OP_REL5: begin
                pram_we    = link_ok(r_free_head, r_count);
                pram_waddr = addr_of(r_free_head);
                pram_wdata = r_node;
            end
            default: begin
                nram_we = 1'b0;
            end
        endcase
    end

    // Pool state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= MAX_CNT;
            r_free_head  <= '0;
            r_used_head  <= NIL_LINK;
            r_used_total <= '0;
            r_nvalid     <= '0;
            r_pvalid     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we || i_ctrl.op == OP_REINIT) begin
                if (i_cfg_we) begin
                    r_count <= cfg_cnt;
                end
                r_free_head  <= '0;
                r_used_head  <= NIL_LINK;
                r_used_total <= '0;
                r_nvalid     <= '0;
                r_pvalid     <= '0;
            end else begin
                unique case (i_ctrl.op)
                    OP_ALLOC_W1: r_free_head <= rd_next;
                    OP_ALLOC_W3: begin
                        r_used_head  <= r_node;
                        r_used_total <= r_used_total + CNT_W'(1);
                    end
                    OP_REL2: begin
                        if (!link_ok(rd_prev, r_count)) begin
                            r_used_head <= rd_next;
                        end
                    end
                    OP_REL5: begin
                        r_free_head <= r_node;
                        if (r_used_total != '0) begin
                            r_used_total <= r_used_total - CNT_W'(1);
                        end
                    end
                    default: begin
                        r_free_head <= r_free_head;
                    end
                endcase
                if (nram_we) begin
                    r_nvalid[nram_waddr] <= 1'b1;
                end
                if (pram_we) begin
                    r_pvalid[pram_waddr] <= 1'b1;
                end
            end
            if (i_ctrl.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk registers, result and output payload.
    always_ff @(posedge i_clk) begin
        r_rd_addr <= raddr;
        r_rd_nv   <= raddr_in_pool && r_nvalid[raddr];
        r_rd_pv   <= raddr_in_pool && r_pvalid[raddr];
        unique case (i_ctrl.op)
            OP_LATCH: begin
                r_cmd  <= i_command;
                r_want <= i_index;
            end
            OP_SET_RES: begin
                r_res_status <= i_ctrl.res_status;
                r_res_idx    <= '0;
                r_res_last   <= 1'b1;
            end
            OP_REINIT: begin
                r_res_status <= ST_OK;
                r_res_idx    <= '0;
                r_res_last   <= 1'b1;
            end
            OP_ALLOC_START: r_node <= r_free_head;
            OP_WALK_START: begin
                r_node  <= r_used_head;
                r_steps <= '0;
            end
            OP_ADV: begin
                r_node  <= rd_next;
                r_steps <= r_steps + CNT_W'(1);
            end
            OP_REL2: begin
                r_pv <= rd_prev;
                r_nx <= rd_next;
            end
            OP_ALLOC_W3, OP_REL5: begin
                r_res_status <= ST_OK;
                r_res_idx    <= r_node[IDX_W-1:0];
                r_res_last   <= 1'b1;
            end
            OP_LIST_RES: begin
                r_nx         <= rd_next;
                r_res_status <= ST_OK;
                r_res_idx    <= r_node[IDX_W-1:0];
                r_res_last   <= list_end;
            end
            OP_EMIT: begin
                r_out_status <= r_res_status;
                r_out_idx    <= r_res_idx;
                r_out_cnt    <= r_used_total;
                r_out_last   <= r_res_last;
                if (!r_res_last) begin
                    r_node  <= r_nx;
                    r_steps <= r_steps + CNT_W'(1);
                end
            end
            default: begin
                r_cmd <= r_cmd;
            end
        endcase
    end

    assign o_stat.cmd           = t_cmd'(r_cmd);
    assign o_stat.pool_full     = (r_used_total >= r_count) || !link_ok(r_free_head, r_count);
    assign o_stat.used_zero     = (r_used_total == '0);
    assign o_stat.head_valid    = link_ok(r_used_head, r_count);
    assign o_stat.node_valid    = link_ok(r_node, r_count);
    assign o_stat.node_eq_want  = (r_node == LINK_W'(r_want));
    assign o_stat.step_limit    = (r_steps >= MAX_CNT);
    assign o_stat.rd_next_valid = link_ok(rd_next, r_count);
    assign o_stat.out_free      = !r_out_valid || i_out_ready;
    assign o_stat.res_last      = r_res_last;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_index_res  = r_out_idx;
    assign o_used_count = r_out_cnt;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire

### src/ifla_checker.sv
// Port-level checker of the index free-list allocator and the bind that
// attaches it to the top level. Depends on ifla_pkg and index_free_list_allocator.
`default_nettype none

module ifla_checker import ifla_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_cmd_valid,
    input wire logic              i_cmd_ready,
    input wire logic              i_res_valid,
    input wire logic              i_res_ready,
    input wire logic [STAT_W-1:0] i_res_status,
    input wire logic [IDX_W-1:0]  i_res_index,
    input wire logic [CNT_W-1:0]  i_res_count,
    input wire logic              i_res_last
);

    // A command beat is followed by a busy command channel.
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready) |=> !i_cmd_ready)
        else $error("command channel ready right after a command beat");

    // The command channel only drops ready because a command was taken.
    a_ready_falls_on_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_cmd_ready) |-> $past(i_cmd_valid && i_cmd_ready))
        else $error("command ready fell without a command beat");

    // Results are produced only while a command is being worked on.
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(!i_cmd_ready))
        else $error("result appeared while the block was idle");

    // A stalled result beat holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_status) && $stable(i_res_index)
             && $stable(i_res_count) && $stable(i_res_last)))
        else $error("stalled result beat changed");

endmodule

bind index_free_list_allocator ifla_checker u_ifla_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_status (o_res.status),
    .i_res_index  (o_res.index_res),
    .i_res_count  (o_res.used_count),
    .i_res_last   (o_res.last)
);

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench of the index free-list allocator: directed and random
// command streams against a behavioural model of the free and used lists.
// Depends on ifla_pkg, the channel interfaces in ifla_ifs and the allocator top level.
`timescale 1ns / 1ps

module tb_top;
    import ifla_pkg::*;

    // Command codes that the block does not decode; each gives one plain beat.
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    // Quiet cycles let through before a count write, and at the very end, which
    // covers the longest walk of a 64-entry used list.
    localparam int CFG_SETTLE    = 8;
    localparam int FINAL_SETTLE  = 150;
    // Cycles without any beat on any channel before the run is declared hung.
    localparam int HANG_LIMIT    = 3000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  index_res;
        logic [CNT_W-1:0]  used_count;
        logic              last;
    } t_alloc_beat;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ifla_cmd_if cmd_if ();
    ifla_res_if res_if ();
    ifla_cfg_if cfg_if ();

    index_free_list_allocator #(
        .MAX_INDICES (MAX_INDICES_DEF)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Model of the pool: link tables, list heads, the number in use and the
    // effective pool size.
    logic [LINK_W-1:0] nxt_tab [MAX_INDICES_DEF];
    logic [LINK_W-1:0] prv_tab [MAX_INDICES_DEF];
    logic [LINK_W-1:0] free_head;
    logic [LINK_W-1:0] used_head;
    int                in_use;
    int                pool_size;

    t_alloc_beat owed_results [$];

    bit pace_on = 1'b1;
    int mismatches;
    int commands_sent;
    int beats_seen;
    int size_writes;

    function automatic bit in_pool(logic [LINK_W-1:0] n);
        return (int'(n) < MAX_INDICES_DEF) && (int'(n) < pool_size);
    endfunction

    // Free list back to 0..size-1 in order, used list empty.
    function automatic void rebuild_lists();
        for (int i = 0; i < MAX_INDICES_DEF; i++) begin
            if (i < pool_size) begin
                nxt_tab[i] = (i + 1 < pool_size) ? LINK_W'(i + 1) : NIL_LINK;
                prv_tab[i] = (i == 0) ? NIL_LINK : LINK_W'(i - 1);
            end else begin
                nxt_tab[i] = NIL_LINK;
                prv_tab[i] = NIL_LINK;
            end
        end
        free_head = '0;
        used_head = NIL_LINK;
        in_use    = 0;
    endfunction

    // Unlink a node from the used list and push it on the head of the free list.
    function automatic void return_to_free(logic [LINK_W-1:0] node);
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] n;
        p = prv_tab[node];
        n = nxt_tab[node];
        if (in_pool(p)) nxt_tab[p] = n;
        else used_head = n;
        if (in_pool(n)) prv_tab[n] = p;
        nxt_tab[node] = free_head;
        prv_tab[node] = NIL_LINK;
        if (in_pool(free_head)) prv_tab[free_head] = node;
        free_head = node;
        if (in_use > 0) in_use--;
    endfunction

    function automatic void owe(t_status st, logic [LINK_W-1:0] idx, logic fin);
        t_alloc_beat beat;
        beat.status     = st;
        beat.index_res  = idx[IDX_W-1:0];
        beat.used_count = CNT_W'(in_use);
        beat.last       = fin;
        owed_results.push_back(beat);
    endfunction

    // Applies one accepted command to the model and queues the beats it owes.
    function automatic void predict_pool_command(logic [CMD_W-1:0] cmd,
                                                 logic [IDX_W-1:0] want);
        logic [LINK_W-1:0] node;
        logic [LINK_W-1:0] nx;
        int                steps;
        bit                done;
        case (cmd)
            CMD_ALLOC: begin
                if (in_use >= pool_size || !in_pool(free_head)) begin
                    owe(ST_EXHAUSTED, '0, 1'b1);
                end else begin
                    node      = free_head;
                    free_head = nxt_tab[node];
                    if (in_pool(free_head)) prv_tab[free_head] = NIL_LINK;
                    nxt_tab[node] = used_head;
                    prv_tab[node] = NIL_LINK;
                    if (in_pool(used_head)) prv_tab[used_head] = node;
                    used_head = node;
                    in_use++;
                    owe(ST_OK, node, 1'b1);
                end
            end
            CMD_RELEASE: begin
                // The empty check wins over the index check.
                if (in_use == 0) begin
                    owe(ST_NONE_IN_USE, '0, 1'b1);
                end else begin
                    node = used_head;
                    done = 1'b0;
                    for (steps = 0; steps < MAX_INDICES_DEF && in_pool(node) && !done;
                         steps++) begin
                        if (node == {1'b0, want}) begin
                            return_to_free(node);
                            owe(ST_OK, node, 1'b1);
                            done = 1'b1;
                        end else begin
                            node = nxt_tab[node];
                        end
                    end
                    if (!done) owe(ST_INVALID, '0, 1'b1);
                end
            end
            CMD_REL_OLDEST: begin
                if (in_use == 0 || !in_pool(used_head)) begin
                    owe(ST_NONE_IN_USE, '0, 1'b1);
                end else begin
                    node = used_head;
                    for (steps = 0; steps < MAX_INDICES_DEF && in_pool(nxt_tab[node]);
                         steps++)
                        node = nxt_tab[node];
                    return_to_free(node);
                    owe(ST_OK, node, 1'b1);
                end
            end
            CMD_REL_ALL: begin
                rebuild_lists();
                owe(ST_OK, '0, 1'b1);
            end
            CMD_LIST: begin
                if (in_use == 0 || !in_pool(used_head)) begin
                    owe(ST_NONE_IN_USE, '0, 1'b1);
                end else begin
                    steps = 0;
                    node  = used_head;
                    done  = 1'b0;
                    while (steps < MAX_INDICES_DEF && in_pool(node) && !done) begin
                        nx   = nxt_tab[node];
                        done = !in_pool(nx) || (steps + 1 >= MAX_INDICES_DEF);
                        owe(ST_OK, node, done);
                        steps++;
                        node = nx;
                    end
                end
            end
            default: owe(ST_OK, '0, 1'b1);
        endcase
    endfunction

    // Some index that is in use at random depth in the used list.
    function automatic logic [IDX_W-1:0] pick_used_index();
        logic [LINK_W-1:0] node;
        int                hops;
        node = used_head;
        hops = $urandom_range(0, in_use - 1);
        repeat (hops) node = nxt_tab[node];
        return node[IDX_W-1:0];
    endfunction

    // Offers one command beat, with an occasional idle burst in front, and
    // returns at the edge where it is taken. Valid stays high afterwards so that
    // back-to-back commands need no low cycle.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
        if (pace_on && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= cmd;
        cmd_if.index   <= idx;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        predict_pool_command(cmd, idx);
        commands_sent++;
    endtask

    task automatic wait_until_idle(input int settle);
        cmd_if.valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_pool_size(input logic [CNT_W-1:0] size_code);
        wait_until_idle(CFG_SETTLE);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= size_code;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        // Zero acts as one, anything above the table size as the table size.
        if (size_code == '0) pool_size = 1;
        else if (int'(size_code) > MAX_INDICES_DEF) pool_size = MAX_INDICES_DEF;
        else pool_size = int'(size_code);
        rebuild_lists();
        size_writes++;
    endtask

    // Empty-pool misuse, ordering of the lists, a release that misses, the
    // spare codes and release all, on the full pool left by reset.
    task automatic test_directed_basics();
        send_cmd(CMD_LIST, 6'd0);
        send_cmd(CMD_RELEASE, 6'd63);
        send_cmd(CMD_REL_OLDEST, 6'd63);
        send_cmd(CMD_ALLOC, 6'd63);
        send_cmd(CMD_ALLOC, 6'd0);
        send_cmd(CMD_ALLOC, 6'd42);
        send_cmd(CMD_LIST, 6'd21);
        send_cmd(CMD_RELEASE, 6'd63);
        send_cmd(CMD_RELEASE, 6'd1);
        send_cmd(CMD_ALLOC, 6'd0);
        send_cmd(CMD_REL_OLDEST, 6'd0);
        send_cmd(CMD_SPARE_FIRST, 6'd63);
        send_cmd(CMD_SPARE_FIRST + 3'd1, 6'd0);
        send_cmd(CMD_SPARE_LAST, 6'd21);
        send_cmd(CMD_LIST, 6'd63);
        send_cmd(CMD_REL_ALL, 6'd42);
        send_cmd(CMD_LIST, 6'd0);
        send_cmd(CMD_ALLOC, 6'd0);
        send_cmd(CMD_RELEASE, 6'd0);
    endtask

    // A one-entry pool, from a written zero and then a written one: exhaustion,
    // release of an index beyond the pool and the empty cases.
    task automatic test_tiny_pool();
        write_pool_size(7'd0);
        send_cmd(CMD_ALLOC, 6'd0);
        send_cmd(CMD_ALLOC, 6'd0);
        send_cmd(CMD_RELEASE, 6'd1);
        send_cmd(CMD_RELEASE, 6'd0);
        send_cmd(CMD_REL_OLDEST, 6'd0);
        write_pool_size(7'd1);
        send_cmd(CMD_ALLOC, 6'd63);
        send_cmd(CMD_LIST, 6'd0);
        send_cmd(CMD_RELEASE, 6'd63);
    endtask

    // An over-range count clamps to the full table; fill it, overflow it and
    // list all 64 entries, then take some back.
    task automatic test_full_pool();
        write_pool_size(7'd127);
        repeat (MAX_INDICES_DEF) send_cmd(CMD_ALLOC, IDX_W'($urandom_range(0, 63)));
        send_cmd(CMD_ALLOC, 6'd0);
        send_cmd(CMD_LIST, 6'd0);
        send_cmd(CMD_RELEASE, 6'd0);
        send_cmd(CMD_REL_OLDEST, 6'd0);
        send_cmd(CMD_RELEASE, 6'd63);
        send_cmd(CMD_LIST, 6'd63);
    endtask

    // Mostly allocations and releases of indices that are really in use, with
    // some stray releases, walks, listings, release all and spare codes mixed in.
    task automatic test_random_traffic(input logic [CNT_W-1:0] size_code, input int n_items);
        int               roll;
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        write_pool_size(size_code);
        repeat (n_items) begin
            roll = $urandom_range(0, 99);
            idx  = IDX_W'($urandom_range(0, 63));
            if (roll < 42) begin
                cmd = CMD_ALLOC;
            end else if (roll < 64) begin
                cmd = CMD_RELEASE;
                if (in_use > 0) idx = pick_used_index();
            end else if (roll < 72) begin
                cmd = CMD_RELEASE;
            end else if (roll < 84) begin
                cmd = CMD_REL_OLDEST;
            end else if (roll < 93) begin
                cmd = CMD_LIST;
            end else if (roll < 96) begin
                cmd = CMD_REL_ALL;
            end else begin
                cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            end
            send_cmd(cmd, idx);
        end
    endtask

    // Result side: ready held high for random stretches, dropped in bursts.
    initial begin
        res_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (pace_on && $urandom_range(0, 4) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Every result beat is matched against the oldest owed beat.
    always @(posedge clk) begin
        t_alloc_beat want;
        if (rst_n && res_if.valid && res_if.ready) begin
            beats_seen++;
            if (owed_results.size() == 0) begin
                mismatches++;
                $error("result beat with nothing owed: status %0d index_res %0d",
                       res_if.status, res_if.index_res);
            end else begin
                want = owed_results.pop_front();
                if (res_if.status !== want.status) begin
                    mismatches++;
                    $error("status: expected %0d, got %0d", want.status, res_if.status);
                end
                if (res_if.index_res !== want.index_res) begin
                    mismatches++;
                    $error("index_res: expected %0d, got %0d",
                           want.index_res, res_if.index_res);
                end
                if (res_if.used_count !== want.used_count) begin
                    mismatches++;
                    $error("used_count: expected %0d, got %0d",
                           want.used_count, res_if.used_count);
                end
                if (res_if.last !== want.last) begin
                    mismatches++;
                    $error("last: expected %0d, got %0d", want.last, res_if.last);
                end
            end
        end
    end

    // Hang detection: any beat on any channel restarts the count.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT) begin
            @(posedge clk);
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no beat on any channel for %0d cycles", HANG_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        cmd_if.valid   <= 1'b0;
        cmd_if.command <= CMD_ALLOC;
        cmd_if.index   <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.data    <= '0;
        pool_size = MAX_INDICES_DEF;
        rebuild_lists();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        test_tiny_pool();
        test_full_pool();
        test_random_traffic(7'd3, 15);
        test_random_traffic(7'd64, 25);
        test_random_traffic(7'd2, 12);
        // Last stretch at full rate on both sides.
        pace_on = 1'b0;
        test_random_traffic(7'd9, 20);

        wait_until_idle(FINAL_SETTLE);
        $display("tb_top: %0d commands, %0d result beats, %0d pool size writes (0, 1, 2, 3, 9, 64, 127).",
                 commands_sent, beats_seen, size_writes);
        $display("tb_top: covered exhaustion, misuse, spare codes, release all and a 64-entry list.");
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
